// ===== rtl/vpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Types, widths and constants shared by the vector pair angle block.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_BITS      = ANGLE_FRAC_BITS + 2;
    localparam int PROD_W          = 2 * COORD_BITS;
    localparam int MAG_W           = PROD_W + 1;
    localparam int NORM_W          = 31;
    localparam int WIDE_W          = MAG_W + NORM_W;
    localparam int LZ_STAGES       = $clog2(WIDE_W);
    localparam int CORDIC_STEPS    = 32;
    localparam int XY_W            = 34;
    localparam int Z_W             = 36;

    localparam logic [Z_W-1:0] QUARTER_PI_Q32 = Z_W'(64'd3373259426);
    localparam logic [Z_W-1:0] HALF_PI_Q32    = Z_W'(64'd6746518852);
    localparam logic [Z_W-1:0] PI_Q32         = Z_W'(64'd13493037705);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
    } t_in;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_rad;
        logic                  zero_vector_error;
    } t_out;

    typedef struct packed {
        logic dneg;
        logic force_zero;
        logic err;
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        logic [MAG_W-1:0] xm;
        logic [MAG_W-1:0] ym;
    } t_cls;

    // atan(2^-i) in Q0.32, alternating series in Q0.62, rounded half up
    function automatic logic [Z_W-1:0] atan_entry(input int i);
        longint          acc;
        longint unsigned num;
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        int              e;
        int              k;
        int              b;
        acc = 0;
        if (i == 0) begin
            return QUARTER_PI_Q32;
        end
        for (k = 0; k < 64; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e < 0) begin
                break;
            end
            num = 64'd1 << e;
            den = 64'(2 * k + 1);
            rem = 0;
            quo = 0;
            for (b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            if (k % 2 == 1) begin
                acc = acc - longint'(quo);
            end else begin
                acc = acc + longint'(quo);
            end
        end
        acc = (acc + (64'sd1 <<< 29)) >>> 30;
        return acc[Z_W-1:0];
    endfunction

endpackage

// ===== rtl/vpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_front
// Takes vector pairs, forms dot and cross products, classifies each beat.
// ----------------------------------------------------------------------------
module vpa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_en,
    input  vpa_pkg::t_in    i_in,
    output logic            o_push,
    output vpa_pkg::t_cls   o_cls
);

    logic                                 r_v1, r_v2, r_v3;
    vpa_pkg::t_in                         r_in;
    logic                                 r_err2;
    logic signed [vpa_pkg::PROD_W-1:0]    r_p_xx, r_p_yy, r_p_xy, r_p_yx;
    vpa_pkg::t_cls                        r_cls;

    logic                                 n_err;
    logic signed [vpa_pkg::MAG_W-1:0]     n_dot, n_cross;
    logic [vpa_pkg::MAG_W-1:0]            n_xm, n_ym;

    always_comb begin
        n_err = ((r_in.first_x == '0) && (r_in.first_y == '0)) ||
                ((r_in.second_x == '0) && (r_in.second_y == '0));
        n_dot   = vpa_pkg::MAG_W'(r_p_xx) + vpa_pkg::MAG_W'(r_p_yy);
        n_cross = vpa_pkg::MAG_W'(r_p_xy) - vpa_pkg::MAG_W'(r_p_yx);
        n_xm    = n_dot[vpa_pkg::MAG_W-1] ? vpa_pkg::MAG_W'(-n_dot) : vpa_pkg::MAG_W'(n_dot);
        n_ym    = n_cross[vpa_pkg::MAG_W-1] ? vpa_pkg::MAG_W'(-n_cross)
                                            : vpa_pkg::MAG_W'(n_cross);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_accept) begin
                r_in <= i_in;
            end
            r_err2 <= n_err;
            r_p_xx <= r_in.first_x * r_in.second_x;
            r_p_yy <= r_in.first_y * r_in.second_y;
            r_p_xy <= r_in.first_x * r_in.second_y;
            r_p_yx <= r_in.first_y * r_in.second_x;
            r_cls.tag.err        <= r_err2;
            r_cls.tag.dneg       <= n_dot[vpa_pkg::MAG_W-1];
            r_cls.tag.force_zero <= r_err2 || ((n_xm == '0) && (n_ym == '0));
            r_cls.xm             <= n_xm;
            r_cls.ym             <= n_ym;
        end
    end

    assign o_push = r_v3 && i_en;
    assign o_cls  = r_cls;

endmodule

// ===== rtl/vpa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_fifo
// Two-entry queue between the classifier and the angle pipeline.
// ----------------------------------------------------------------------------
module vpa_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vpa_pkg::t_cls   i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output vpa_pkg::t_cls   o_data
);

    vpa_pkg::t_cls  r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

// ===== rtl/vpa_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_norm
// Pipelined normalizer: puts max(|dot|, |cross|) into [2^30, 2^31).
// ----------------------------------------------------------------------------
module vpa_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  vpa_pkg::t_cls                i_cls,
    output logic                         o_valid,
    output vpa_pkg::t_tag                o_tag,
    output logic [vpa_pkg::NORM_W-1:0]   o_x,
    output logic [vpa_pkg::NORM_W-1:0]   o_y
);

    localparam int W = vpa_pkg::WIDE_W;
    localparam int S = vpa_pkg::LZ_STAGES;

    logic                 r_v   [S+1];
    vpa_pkg::t_tag        r_tag [S+1];
    logic [W-1:0]         r_x   [S+1];
    logic [W-1:0]         r_y   [S+1];
    logic [W-1:0]         r_m   [S+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_cls.tag;
        r_x[0]   <= {i_cls.xm, {vpa_pkg::NORM_W{1'b0}}};
        r_y[0]   <= {i_cls.ym, {vpa_pkg::NORM_W{1'b0}}};
        r_m[0]   <= (i_cls.xm > i_cls.ym) ? {i_cls.xm, {vpa_pkg::NORM_W{1'b0}}}
                                          : {i_cls.ym, {vpa_pkg::NORM_W{1'b0}}};
    end

    for (genvar k = 0; k < S; k++) begin : g_stage
        localparam int SH = 1 << (S - 1 - k);
        logic n_sh;
        assign n_sh = (r_m[k][W-1 -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k+1] <= r_tag[k];
            r_x[k+1]   <= n_sh ? (r_x[k] << SH) : r_x[k];
            r_y[k+1]   <= n_sh ? (r_y[k] << SH) : r_y[k];
            r_m[k+1]   <= n_sh ? (r_m[k] << SH) : r_m[k];
        end
    end

    assign o_valid = r_v[S];
    assign o_tag   = r_tag[S];
    assign o_x     = r_x[S][W-1 -: vpa_pkg::NORM_W];
    assign o_y     = r_y[S][W-1 -: vpa_pkg::NORM_W];

endmodule

// ===== rtl/vpa_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_cordic
// Pipelined vectoring CORDIC, one stage per iteration, then angle rounding.
// ----------------------------------------------------------------------------
module vpa_cordic (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  vpa_pkg::t_tag                i_tag,
    input  logic [vpa_pkg::NORM_W-1:0]   i_x,
    input  logic [vpa_pkg::NORM_W-1:0]   i_y,
    output logic                         o_valid,
    output vpa_pkg::t_out                o_result
);

    localparam int N  = vpa_pkg::CORDIC_STEPS;
    localparam int XW = vpa_pkg::XY_W;
    localparam int ZW = vpa_pkg::Z_W;
    localparam int F  = vpa_pkg::ANGLE_FRAC_BITS;

    logic                 r_v   [N+1];
    vpa_pkg::t_tag        r_tag [N+1];
    logic signed [XW-1:0] r_x   [N+1];
    logic signed [XW-1:0] r_y   [N+1];
    logic signed [ZW-1:0] r_z   [N+1];

    logic                 r_ov;
    vpa_pkg::t_out        r_out;

    logic signed [ZW-1:0] n_zc;
    logic [ZW-1:0]        n_theta;
    logic [ZW-1:0]        n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_x[0]   <= XW'(i_x);
        r_y[0]   <= XW'(i_y);
        r_z[0]   <= '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic [ZW-1:0] T = vpa_pkg::atan_entry(i);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[i+1] <= r_tag[i];
            if (!r_y[i][XW-1]) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + signed'(T);
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - signed'(T);
            end
        end
    end

    always_comb begin
        if (r_z[N][ZW-1]) begin
            n_zc = '0;
        end else if (r_z[N] > signed'(vpa_pkg::HALF_PI_Q32)) begin
            n_zc = signed'(vpa_pkg::HALF_PI_Q32);
        end else begin
            n_zc = r_z[N];
        end
        n_theta = r_tag[N].dneg ? (vpa_pkg::PI_Q32 - unsigned'(n_zc)) : unsigned'(n_zc);
        n_sum   = n_theta + (ZW'(1) << (31 - F));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.zero_vector_error <= r_tag[N].err;
        r_out.angle_rad         <= r_tag[N].force_zero ? '0
                                   : n_sum[32-F +: vpa_pkg::ANGLE_BITS];
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule

// ===== rtl/vector_pair_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_pair_angle
// Unsigned angle between two 2-D vectors, |atan2(cross, dot)| in Q2.13.
// ----------------------------------------------------------------------------
//  channel   signals                       direction  rule
//  command   start, busy, i_in             in         taken when start && !busy
//  result    o_valid, o_result             out        one-cycle strobe, no stall
//
//  One beat per cycle while busy is low; the front (3 stages), queue (1),
//  normalizer (7 stages), CORDIC (input register plus 32 stages, one per
//  iteration) and output register are all pipelined.
//  busy rises only when the two-entry queue is full, which a non-stalling
//  back end never lets happen; reset empties every stage.
module vector_pair_angle (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  vpa_pkg::t_in    i_in,
    output logic            o_valid,
    output vpa_pkg::t_out   o_result
);

    logic                           w_full, w_empty, w_push, w_en;
    vpa_pkg::t_cls                  w_cls, w_head;
    logic                           w_nv;
    vpa_pkg::t_tag                  w_ntag;
    logic [vpa_pkg::NORM_W-1:0]     w_nx, w_ny;

    assign w_en = !w_full;
    assign busy = w_full;

    vpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(start && !w_full),
        .i_en    (w_en),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_cls   (w_cls)
    );

    vpa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls),
        .i_pop   (!w_empty),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    vpa_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_cls   (w_head),
        .o_valid (w_nv),
        .o_tag   (w_ntag),
        .o_x     (w_nx),
        .o_y     (w_ny)
    );

    vpa_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_nv),
        .i_tag    (w_ntag),
        .i_x      (w_nx),
        .i_y      (w_ny),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.zero_vector_error |-> o_result.angle_rad == '0)
        else $error("error beat with nonzero angle");

    a_angle_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.angle_rad <= vpa_pkg::ANGLE_BITS'(
            (vpa_pkg::PI_Q32 + (vpa_pkg::Z_W'(1) << (31 - vpa_pkg::ANGLE_FRAC_BITS)))
            >> (32 - vpa_pkg::ANGLE_FRAC_BITS)))
        else $error("angle above pi");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("queue overflow");
`endif

endmodule
